[rtl/core/imadec_pkg.sv]
// shared types, constants and tables of the ima adpcm block decoder
`timescale 1ns / 1ps

package imadec_pkg;

    localparam logic [15:0] BLOCK_ALIGN_RESET = 16'd256;
    localparam logic [6:0]  STEP_MAX          = 7'd88;

    // byte positions inside the block header
    localparam logic [15:0] POS_PRED_LO  = 16'd0;
    localparam logic [15:0] POS_PRED_HI  = 16'd1;
    localparam logic [15:0] POS_STEP_IDX = 16'd2;
    localparam logic [15:0] POS_RESERVED = 16'd3;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               from_header;
        logic               end_of_block;
        logic               last;
    } result_t;

    typedef struct packed {
        logic load;   // push results this cycle
        logic two;    // push both slots, else slot 0 only
    } buf_ctl_t;

    function automatic logic [14:0] step_size(input logic [6:0] idx);
        logic [14:0] s;
        case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

    function automatic logic signed [7:0] index_adjust(input logic [2:0] code);
        logic signed [7:0] a;
        case (code)
            3'd4:    a = 8'sd2;
            3'd5:    a = 8'sd4;
            3'd6:    a = 8'sd6;
            3'd7:    a = 8'sd8;
            default: a = -8'sd1;
        endcase
        return a;
    endfunction

endpackage

[rtl/core/ima_adpcm_block_decoder_unit.sv]
// top level of the mono 4-bit ima adpcm block decoder
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// s_        in         s_valid / s_ready      s_data_byte[7:0]
// m_        out        m_valid / m_ready      m_sample[15:0], m_from_header,
//                                             m_end_of_block, m_last
// cfg_      in         cfg_valid / cfg_ready  cfg_data[15:0] (block_align)
//
// header bytes 0 to 2 give no result; a data byte gives two samples, one per
// output beat, since the result port moves one sample per beat
// a byte passes the input register, then the result slots of the output buffer
// reset (aresetn low, synchronous) returns to the start of a header and
// sets block_align to 256
// a stalled m_ side still lets bytes in until one with a result must wait

module ima_adpcm_block_decoder_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_sample,
    output logic               m_from_header,
    output logic               m_end_of_block,
    output logic               m_last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data
);

    // configuration
    logic [15:0] block_align_reg;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // decoder state
    logic signed [15:0] pred_reg;
    logic signed [15:0] pred_next;
    logic [6:0]         step_reg;
    logic [6:0]         step_next;
    logic [15:0]        pos_reg;
    logic [15:0]        pos_next;
    logic [7:0]         hdr_lo_reg;
    logic [7:0]         hdr_lo_next;

    // nibble chain
    logic signed [15:0] pred_lo;
    logic [6:0]         step_lo;
    logic signed [15:0] pred_hi;
    logic [6:0]         step_hi;

    logic                 ends;
    logic                 has_result;
    logic                 is_data;
    logic                 can_load;
    logic                 fire;
    imadec_pkg::buf_ctl_t ctl;
    imadec_pkg::result_t  res0;
    imadec_pkg::result_t  res1;
    imadec_pkg::result_t  m_res;

    assign cfg_ready = 1'b1;

    // block ends from the reserved byte on, once pos + 1 reaches block_align
    assign ends       = (pos_reg >= imadec_pkg::POS_RESERVED)
                     && (({1'b0, pos_reg} + 17'd1) >= {1'b0, block_align_reg});
    assign has_result = pos_reg >= imadec_pkg::POS_RESERVED;
    assign is_data    = pos_reg > imadec_pkg::POS_RESERVED;

    // header bytes with no result never wait on the output side
    assign fire    = in_valid_reg && (!has_result || can_load);
    assign s_ready = !in_valid_reg || fire;

    // low nibble first, high nibble continues from its state
    imadec_nibble u_nib_lo (
        .pred_in  (pred_reg),
        .idx_in   (step_reg),
        .nib      (in_byte_reg[3:0]),
        .pred_out (pred_lo),
        .idx_out  (step_lo)
    );

    imadec_nibble u_nib_hi (
        .pred_in  (pred_lo),
        .idx_in   (step_lo),
        .nib      (in_byte_reg[7:4]),
        .pred_out (pred_hi),
        .idx_out  (step_hi)
    );

    always_comb begin
        pred_next   = pred_reg;
        step_next   = step_reg;
        hdr_lo_next = hdr_lo_reg;
        pos_next    = pos_reg;
        if (fire) begin
            case (pos_reg)
                imadec_pkg::POS_PRED_LO: begin
                    hdr_lo_next = in_byte_reg;
                end
                imadec_pkg::POS_PRED_HI: begin
                    pred_next = $signed({in_byte_reg, hdr_lo_reg});
                end
                imadec_pkg::POS_STEP_IDX: begin
                    // header step index saturates to the table top
                    step_next = (in_byte_reg > {1'b0, imadec_pkg::STEP_MAX})
                              ? imadec_pkg::STEP_MAX : in_byte_reg[6:0];
                end
                imadec_pkg::POS_RESERVED: begin
                    pred_next = pred_reg;
                end
                default: begin
                    pred_next = pred_hi;
                    step_next = step_hi;
                end
            endcase
            pos_next = ends ? 16'd0 : (pos_reg + 16'd1);
        end
    end

    // reserved header byte shows the header predictor in slot 0
    always_comb begin
        if (is_data) begin
            res0.sample       = pred_lo;
            res0.from_header  = 1'b0;
            res0.end_of_block = 1'b0;
            res0.last         = 1'b0;
        end else begin
            res0.sample       = pred_reg;
            res0.from_header  = 1'b1;
            res0.end_of_block = ends;
            res0.last         = 1'b1;
        end
        res1.sample       = pred_hi;
        res1.from_header  = 1'b0;
        res1.end_of_block = ends;
        res1.last         = 1'b1;
        ctl.load          = fire && has_result;
        ctl.two           = is_data;
    end

    imadec_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .res0     (res0),
        .res1     (res1),
        .can_load (can_load),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_res    (m_res)
    );

    assign m_sample       = m_res.sample;
    assign m_from_header  = m_res.from_header;
    assign m_end_of_block = m_res.end_of_block;
    assign m_last         = m_res.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_align_reg <= imadec_pkg::BLOCK_ALIGN_RESET;
            in_valid_reg    <= 1'b0;
            pred_reg        <= 16'sd0;
            step_reg        <= 7'd0;
            pos_reg         <= 16'd0;
            hdr_lo_reg      <= 8'd0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                block_align_reg <= cfg_data;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            pred_reg   <= pred_next;
            step_reg   <= step_next;
            pos_reg    <= pos_next;
            hdr_lo_reg <= hdr_lo_next;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

endmodule

[rtl/core/imadec_nibble.sv]
// one ima adpcm nibble update: predictor and step index
`timescale 1ns / 1ps

module imadec_nibble (
    input  logic signed [15:0] pred_in,
    input  logic [6:0]         idx_in,
    input  logic [3:0]         nib,
    output logic signed [15:0] pred_out,
    output logic [6:0]         idx_out
);

    logic [6:0]         pos;
    logic [14:0]        step;
    logic [16:0]        diff;
    logic signed [17:0] pred_ext;
    logic signed [17:0] diff_ext;
    logic signed [17:0] sum;
    logic signed [7:0]  idx_sum;

    always_comb begin
        pos  = (idx_in > imadec_pkg::STEP_MAX) ? imadec_pkg::STEP_MAX : idx_in;
        step = imadec_pkg::step_size(pos);
        diff = {5'd0, step[14:3]}
             + (nib[2] ? {2'd0, step} : 17'd0)
             + (nib[1] ? {3'd0, step[14:1]} : 17'd0)
             + (nib[0] ? {4'd0, step[14:2]} : 17'd0);
        pred_ext = {{2{pred_in[15]}}, pred_in};
        diff_ext = $signed({1'b0, diff});
        sum = nib[3] ? (pred_ext - diff_ext) : (pred_ext + diff_ext);
        if (sum > 18'sd32767) begin
            pred_out = 16'sh7fff;
        end else if (sum < -18'sd32768) begin
            pred_out = 16'sh8000;
        end else begin
            pred_out = sum[15:0];
        end
        idx_sum = $signed({1'b0, pos}) + imadec_pkg::index_adjust(nib[2:0]);
        if (idx_sum < 8'sd0) begin
            idx_out = 7'd0;
        end else if (idx_sum > $signed({1'b0, imadec_pkg::STEP_MAX})) begin
            idx_out = imadec_pkg::STEP_MAX;
        end else begin
            idx_out = idx_sum[6:0];
        end
    end

endmodule

[rtl/core/imadec_out_buf.sv]
// two-slot result register that hands out one sample per beat
`timescale 1ns / 1ps

module imadec_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  imadec_pkg::buf_ctl_t ctl,
    input  imadec_pkg::result_t  res0,
    input  imadec_pkg::result_t  res1,
    output logic                 can_load,
    input  logic                 m_ready,
    output logic                 m_valid,
    output imadec_pkg::result_t  m_res
);

    imadec_pkg::result_t slot0_reg;
    imadec_pkg::result_t slot1_reg;
    logic                v0_reg;
    logic                v1_reg;
    logic                v0_next;
    logic                v1_next;

    assign m_valid  = v0_reg | v1_reg;
    assign m_res    = v0_reg ? slot0_reg : slot1_reg;
    // empty now, or the only remaining result leaves this cycle
    assign can_load = !m_valid || (m_ready && (v0_reg ^ v1_reg));

    always_comb begin
        v0_next = v0_reg;
        v1_next = v1_reg;
        if (m_ready && v0_reg) begin
            v0_next = 1'b0;
        end else if (m_ready && v1_reg) begin
            v1_next = 1'b0;
        end
        if (ctl.load && can_load) begin
            v0_next = 1'b1;
            v1_next = ctl.two;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
        if (ctl.load && can_load) begin
            slot0_reg <= res0;
            slot1_reg <= res1;
        end
    end

endmodule

[rtl/core/imadec_checker.sv]
// port-level checks of the ima adpcm block decoder and their bind
`timescale 1ns / 1ps

module imadec_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_sample,
    input logic               m_from_header,
    input logic               m_end_of_block,
    input logic               m_last
);

    // stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample) && $stable(m_last)
            && $stable(m_from_header) && $stable(m_end_of_block))
        else $error("stalled result beat changed");

    // header sample is the only result of its byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_from_header |-> m_last)
        else $error("header sample without last");

    // block end falls on the final result of a byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_block |-> m_last)
        else $error("end of block on a non-final sample");

    // the second sample of a data byte follows at once
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid && !m_from_header)
        else $error("second sample of a data byte missing");

endmodule

bind ima_adpcm_block_decoder_unit imadec_checker u_checker (.*);
